// ===== hdl/trs_model_matrix_defines.svh =====
// Assertion macros shared by the transform matrix block
`ifndef TRS_MODEL_MATRIX_DEFINES_SVH
`define TRS_MODEL_MATRIX_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/trs_pkg.sv =====
// Shared types and constants for the transform matrix block
package trs_pkg;

  // Latency of the sine and cosine pipeline
  localparam int SC_LAT = 11;

  // Angle reduction, units of 1/64 degree
  localparam logic [16:0] TURN_1 = 17'd23040;
  localparam logic [16:0] TURN_2 = 17'd46080;
  localparam logic [16:0] TURN_3 = 17'd69120;
  localparam logic [14:0] QTR_1  = 15'd5760;
  localparam logic [14:0] QTR_2  = 15'd11520;
  localparam logic [14:0] QTR_3  = 15'd17280;
  localparam logic [12:0] QTR    = 13'd5760;
  localparam logic [12:0] EIGHTH = 13'd2880;

  // One angle step in radians, Q2.30
  localparam logic [18:0] RAD_STEP = 19'd292818;
  localparam logic [30:0] ONE30    = 31'h4000_0000;

  // Series divisors and their reciprocals (floor of 2^32 / d)
  localparam int DIV_N = 7;
  localparam int D72 = 0;
  localparam int D42 = 1;
  localparam int D20 = 2;
  localparam int D6  = 3;
  localparam int D56 = 4;
  localparam int D30 = 5;
  localparam int D12 = 6;
  localparam logic [6:0] DIVISOR [DIV_N] = '{7'd72, 7'd42, 7'd20, 7'd6, 7'd56, 7'd30, 7'd12};
  localparam logic [31:0] RECIP [DIV_N] = '{
    32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6),
    32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12)};

  localparam logic [1:0] LAST_COL = 2'd3;

  // Fields that travel beside the angle pipelines
  typedef struct packed {
    logic            func;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] scl;
  } xf_t;

endpackage

// ===== hdl/trs_ifs.sv =====
// Channel interfaces for the transform matrix block
interface trs_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;

  modport source (output valid, func, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, func, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column;
  logic signed [31:0] row0_value;
  logic signed [31:0] row1_value;
  logic signed [31:0] row2_value;
  logic signed [31:0] row3_value;
  logic               saturated;
  logic               last;

  modport source (output valid, column, row0_value, row1_value, row2_value, row3_value,
                  saturated, last, input ready);
  modport sink (input valid, column, row0_value, row1_value, row2_value, row3_value,
                saturated, last, output ready);
endinterface

// ===== hdl/trs_sincos.sv =====
// Pipelined sine and cosine of an angle in 1/64 degree, result in signed fixed point
module trs_sincos #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [15:0]        angle,
  output logic signed [FRAC_BITS+1:0] sin_q,
  output logic signed [FRAC_BITS+1:0] cos_q
);

  localparam int SC_W = FRAC_BITS + 2;
  localparam int DIV_N_L = trs_pkg::DIV_N;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } ctl_t;

  function automatic logic [30:0] q30mul(input logic [29:0] a, input logic [30:0] t);
    logic [61:0] p;
    p = a * t + (62'd1 << 29);
    return 31'(p >> 30);
  endfunction

  // Stage registers
  logic [14:0] m1_r, m1_nxt;
  logic [11:0] r2_r, r2_nxt;
  ctl_t        ctl_r [9];
  ctl_t        ctl_nxt;
  logic [29:0] x3_r, x3_nxt, x4_r, x5_r, x6_r, x7_r, x8_r, x9_r;
  logic [29:0] x2_4_r, x2_4_nxt, x2_5_r, x2_6_r, x2_7_r, x2_8_r;
  logic [29:0] q0_r [DIV_N_L];
  logic [29:0] q0_nxt [DIV_N_L];
  logic [29:0] dq_r [DIV_N_L];
  logic [29:0] dq_nxt [DIV_N_L];
  logic [29:0] d20_7_r, d12_7_r, d6_7_r, d6_8_r;
  logic [30:0] ts7_r, ts7_nxt, tc7_r, tc7_nxt, ts8_r, ts8_nxt, tc8_r, tc8_nxt;
  logic [30:0] ts9_r, ts9_nxt, c9_r, c9_nxt, s10_r, s10_nxt, c10_r;
  logic signed [SC_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;

  // Intermediates
  int          ai;
  logic [16:0] u;
  logic [12:0] rr;
  logic [30:0] px;
  logic [60:0] pxx;
  logic [61:0] pr;
  logic [36:0] prd;
  logic [36:0] rem;
  logic [31:0] srnd, crnd;
  logic signed [SC_W-1:0] sv, cv, st, ct;

  // Reduce modulo a full turn
  always_comb begin
    ai = int'(angle);
    u  = 17'(ai + 46080);
    if (u >= trs_pkg::TURN_3) begin
      m1_nxt = 15'(u - trs_pkg::TURN_3);
    end else if (u >= trs_pkg::TURN_2) begin
      m1_nxt = 15'(u - trs_pkg::TURN_2);
    end else if (u >= trs_pkg::TURN_1) begin
      m1_nxt = 15'(u - trs_pkg::TURN_1);
    end else begin
      m1_nxt = 15'(u);
    end
  end

  // Split into quadrant and remainder, fold the upper octant
  always_comb begin
    if (m1_r >= trs_pkg::QTR_3) begin
      ctl_nxt.quad = 2'd3;
      rr = 13'(m1_r - trs_pkg::QTR_3);
    end else if (m1_r >= trs_pkg::QTR_2) begin
      ctl_nxt.quad = 2'd2;
      rr = 13'(m1_r - trs_pkg::QTR_2);
    end else if (m1_r >= trs_pkg::QTR_1) begin
      ctl_nxt.quad = 2'd1;
      rr = 13'(m1_r - trs_pkg::QTR_1);
    end else begin
      ctl_nxt.quad = 2'd0;
      rr = 13'(m1_r);
    end
    ctl_nxt.swap = 1'b0;
    if (rr > trs_pkg::EIGHTH) begin
      rr = trs_pkg::QTR - rr;
      ctl_nxt.swap = 1'b1;
    end
    r2_nxt = 12'(rr);
  end

  // Radians, then the square
  always_comb begin
    px       = r2_r * trs_pkg::RAD_STEP;
    x3_nxt   = 30'(px);
    pxx      = x3_r * x3_r + (61'd1 << 29);
    x2_4_nxt = 30'(pxx >> 30);
  end

  // Divide the square by each series constant: reciprocal estimate, then one correction
  always_comb begin
    pr  = '0;
    prd = '0;
    rem = '0;
    for (int i = 0; i < DIV_N_L; i++) begin
      pr        = x2_4_r * trs_pkg::RECIP[i];
      q0_nxt[i] = 30'(pr >> 32);
    end
    for (int i = 0; i < DIV_N_L; i++) begin
      prd = q0_r[i] * trs_pkg::DIVISOR[i];
      rem = {7'd0, x2_5_r} - prd;
      if (rem >= 37'(trs_pkg::DIVISOR[i])) begin
        dq_nxt[i] = q0_r[i] + 30'd1;
      end else begin
        dq_nxt[i] = q0_r[i];
      end
    end
  end

  // Nested series, one product level per stage
  always_comb begin
    ts7_nxt = trs_pkg::ONE30 - q30mul(dq_r[trs_pkg::D42],
                                      trs_pkg::ONE30 - 31'(dq_r[trs_pkg::D72]));
    tc7_nxt = trs_pkg::ONE30 - q30mul(dq_r[trs_pkg::D30],
                                      trs_pkg::ONE30 - 31'(dq_r[trs_pkg::D56]));
    ts8_nxt = trs_pkg::ONE30 - q30mul(d20_7_r, ts7_r);
    tc8_nxt = trs_pkg::ONE30 - q30mul(d12_7_r, tc7_r);
    ts9_nxt = trs_pkg::ONE30 - q30mul(d6_8_r, ts8_r);
    c9_nxt  = trs_pkg::ONE30 - q30mul(x2_8_r >> 1, tc8_r);
    s10_nxt = q30mul(x9_r, ts9_r);
  end

  // Round to output format, undo the fold, apply the quadrant
  always_comb begin
    srnd = {1'b0, s10_r} + (32'd1 << (29 - FRAC_BITS));
    crnd = {1'b0, c10_r} + (32'd1 << (29 - FRAC_BITS));
    sv   = $signed(SC_W'(srnd >> (30 - FRAC_BITS)));
    cv   = $signed(SC_W'(crnd >> (30 - FRAC_BITS)));
    if (ctl_r[8].swap) begin
      st = cv;
      ct = sv;
    end else begin
      st = sv;
      ct = cv;
    end
    case (ctl_r[8].quad)
      2'd1: begin
        sin_nxt = ct;
        cos_nxt = -st;
      end
      2'd2: begin
        sin_nxt = -st;
        cos_nxt = -ct;
      end
      2'd3: begin
        sin_nxt = -ct;
        cos_nxt = st;
      end
      default: begin
        sin_nxt = st;
        cos_nxt = ct;
      end
    endcase
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_nxt;
      r2_r   <= r2_nxt;
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k < 9; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      x3_r   <= x3_nxt;
      x4_r   <= x3_r;
      x5_r   <= x4_r;
      x6_r   <= x5_r;
      x7_r   <= x6_r;
      x8_r   <= x7_r;
      x9_r   <= x8_r;
      x2_4_r <= x2_4_nxt;
      x2_5_r <= x2_4_r;
      x2_6_r <= x2_5_r;
      x2_7_r <= x2_6_r;
      x2_8_r <= x2_7_r;
      q0_r   <= q0_nxt;
      dq_r   <= dq_nxt;
      d20_7_r <= dq_r[trs_pkg::D20];
      d12_7_r <= dq_r[trs_pkg::D12];
      d6_7_r  <= dq_r[trs_pkg::D6];
      d6_8_r  <= d6_7_r;
      ts7_r  <= ts7_nxt;
      tc7_r  <= tc7_nxt;
      ts8_r  <= ts8_nxt;
      tc8_r  <= tc8_nxt;
      ts9_r  <= ts9_nxt;
      c9_r   <= c9_nxt;
      s10_r  <= s10_nxt;
      c10_r  <= c9_r;
      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
    end
  end

  // Drive the outputs from the last stage
  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

// ===== hdl/trs_model_matrix.sv =====
// Transform matrix builder: position, scale and Euler angles to a 4x4 column-major matrix
//
// Each accepted transaction yields four result transactions, columns 0 to 3 in order,
// with last on column 3. An input passes through the sine and cosine pipelines (one per
// angle), then registers for the rotation products, the rotation matrix, scaling and
// clamping, and then the output buffer. The output buffer sets the input rate: it sends
// one column per cycle while the result side is ready; the next transform waits at the
// end of the pipeline meanwhile. The block holds no state between transforms and
// needs no warm-up after reset.
module trs_model_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);

`include "trs_model_matrix_defines.svh"

  localparam int SC_W  = FRAC_BITS + 2;
  localparam int RW    = SC_W + 1;
  localparam int EP_W  = 32 + RW;
  localparam int EL_W  = EP_W - FRAC_BITS;
  localparam int TR_W  = 64 - FRAC_BITS;
  localparam int LAT   = trs_pkg::SC_LAT;
  localparam logic signed [2*SC_W-1:0] HALF_SC = (2*SC_W)'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [EP_W-1:0]   HALF_EL = EP_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [63:0]       HALF_TR = 64'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [TR_W-1:0]   MAX_V   = TR_W'(64'sd2147483647);
  localparam logic signed [TR_W-1:0]   MIN_V   = TR_W'(-64'sd2147483648);
  localparam logic signed [31:0]       ONE_Q   = 32'(64'd1 << FRAC_BITS);

  function automatic logic signed [SC_W-1:0] qm_sc(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b;
    p = p + HALF_SC;
    return SC_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [EL_W-1:0] qm_el(input logic signed [31:0] a,
                                                   input logic signed [RW-1:0] b);
    logic signed [EP_W-1:0] p;
    p = a * b;
    p = p + HALF_EL;
    return EL_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [TR_W-1:0] qm_tr(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + HALF_TR;
    return TR_W'(p >>> FRAC_BITS);
  endfunction

  // Pipeline control
  logic             en;
  logic             ser_take;
  logic             ser_load;
  logic [LAT-1:0]   v_r;
  logic             v12_r, v13_r, v14_r, v15_r;
  trs_pkg::xf_t     xf_in;
  trs_pkg::xf_t     xf_r [LAT];
  trs_pkg::xf_t     xf12_r, xf13_r;

  logic signed [SC_W-1:0] sx, cx, sy, cy, sz, cz;

  // Rotation product stage
  logic signed [SC_W-1:0] cycz_r, cysz_r, sxsy_r, cxsy_r, cxsz_r, cxcz_r;
  logic signed [SC_W-1:0] sxcy_r, sxsz_r, sxcz_r, cxcy_r, sy12_r;
  logic signed [SC_W-1:0] cz_d, sz_d;
  logic signed [RW-1:0]   rot_r [3][3];
  logic signed [RW-1:0]   rot_nxt [3][3];
  logic signed [EL_W-1:0] el_r [3][3];
  logic signed [EL_W-1:0] el_nxt [3][3];
  logic signed [TR_W-1:0] tr_r [3];
  logic signed [TR_W-1:0] tr_nxt [3];
  logic signed [31:0]     mat15_r [4][3];
  logic signed [31:0]     mat15_nxt [4][3];
  logic [3:0]             sat15_r, sat15_nxt;
  logic signed [TR_W-1:0] pre;

  // Output buffer
  logic signed [31:0] mat_r [4][3];
  logic [3:0]         sat_r;
  logic               ser_v_r;
  logic [1:0]         col_r;

  assign xf_in.func = in_ch.func;
  assign xf_in.pos  = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
  assign xf_in.scl  = {in_ch.scale_z, in_ch.scale_y, in_ch.scale_x};

  // Stall the whole pipeline only while a finished matrix cannot enter the buffer
  assign ser_take    = !ser_v_r || (out_ch.ready && col_r == trs_pkg::LAST_COL);
  assign en          = !v15_r || ser_take;
  assign ser_load    = v15_r && ser_take;
  assign in_ch.ready = en;

  trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .en(en), .angle(in_ch.angle_x), .sin_q(sx), .cos_q(cx));
  trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .en(en), .angle(in_ch.angle_y), .sin_q(sy), .cos_q(cy));
  trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .en(en), .angle(in_ch.angle_z), .sin_q(sz), .cos_q(cz));

  // Combine partial products into the rotation matrix
  always_comb begin
    rot_nxt[0][0] = RW'(cycz_r);
    rot_nxt[0][1] = -RW'(cysz_r);
    rot_nxt[0][2] = RW'(sy12_r);
    rot_nxt[1][0] = RW'(qm_sc(sxsy_r, cz_d)) + RW'(cxsz_r);
    rot_nxt[1][1] = -RW'(qm_sc(sxsy_r, sz_d)) + RW'(cxcz_r);
    rot_nxt[1][2] = -RW'(sxcy_r);
    rot_nxt[2][0] = -RW'(qm_sc(cxsy_r, cz_d)) + RW'(sxsz_r);
    rot_nxt[2][1] = RW'(qm_sc(cxsy_r, sz_d)) + RW'(sxcz_r);
    rot_nxt[2][2] = RW'(cxcy_r);
  end

  // Scale rows, build the translation column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        el_nxt[i][j] = qm_el($signed(xf13_r.scl[i]), rot_r[i][j]);
      end
      if (xf13_r.func) begin
        tr_nxt[i] = TR_W'($signed(xf13_r.pos[i]));
      end else begin
        tr_nxt[i] = qm_tr($signed(xf13_r.scl[i]), $signed(xf13_r.pos[i]));
      end
    end
  end

  // Clamp each element to 32 bits and flag the column
  always_comb begin
    sat15_nxt = '0;
    pre       = '0;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (j < 3) begin
          pre = TR_W'(el_r[i][j]);
        end else begin
          pre = tr_r[i];
        end
        if (pre > MAX_V) begin
          mat15_nxt[j][i] = 32'(MAX_V);
          sat15_nxt[j]    = 1'b1;
        end else if (pre < MIN_V) begin
          mat15_nxt[j][i] = 32'(MIN_V);
          sat15_nxt[j]    = 1'b1;
        end else begin
          mat15_nxt[j][i] = 32'(pre);
        end
      end
    end
  end

  // Valid bits and output sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      v12_r   <= 1'b0;
      v13_r   <= 1'b0;
      v14_r   <= 1'b0;
      v15_r   <= 1'b0;
      ser_v_r <= 1'b0;
      col_r   <= '0;
    end else begin
      if (en) begin
        v_r   <= {v_r[LAT-2:0], in_ch.valid};
        v12_r <= v_r[LAT-1];
        v13_r <= v12_r;
        v14_r <= v13_r;
        v15_r <= v14_r;
      end
      if (ser_load) begin
        ser_v_r <= 1'b1;
        col_r   <= '0;
      end else if (ser_v_r && out_ch.ready) begin
        if (col_r == trs_pkg::LAST_COL) begin
          ser_v_r <= 1'b0;
        end
        col_r <= col_r + 2'd1;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      xf_r[0] <= xf_in;
      for (int k = 1; k < LAT; k++) begin
        xf_r[k] <= xf_r[k-1];
      end
      xf12_r <= xf_r[LAT-1];
      xf13_r <= xf12_r;
      cycz_r <= qm_sc(cy, cz);
      cysz_r <= qm_sc(cy, sz);
      sxsy_r <= qm_sc(sx, sy);
      cxsy_r <= qm_sc(cx, sy);
      cxsz_r <= qm_sc(cx, sz);
      cxcz_r <= qm_sc(cx, cz);
      sxcy_r <= qm_sc(sx, cy);
      sxsz_r <= qm_sc(sx, sz);
      sxcz_r <= qm_sc(sx, cz);
      cxcy_r <= qm_sc(cx, cy);
      sy12_r <= sy;
      cz_d   <= cz;
      sz_d   <= sz;
      rot_r  <= rot_nxt;
      el_r   <= el_nxt;
      tr_r   <= tr_nxt;
      mat15_r <= mat15_nxt;
      sat15_r <= sat15_nxt;
    end
    if (ser_load) begin
      mat_r <= mat15_r;
      sat_r <= sat15_r;
    end
  end

  // Present the current column
  assign out_ch.valid      = ser_v_r;
  assign out_ch.column     = col_r;
  assign out_ch.row0_value = mat_r[col_r][0];
  assign out_ch.row1_value = mat_r[col_r][1];
  assign out_ch.row2_value = mat_r[col_r][2];
  assign out_ch.last       = (col_r == trs_pkg::LAST_COL);
  assign out_ch.row3_value = out_ch.last ? ONE_Q : '0;
  assign out_ch.saturated  = sat_r[col_r];

  // Columns step by one within a matrix
  `TRS_ASSERT_NEXT(a_col_step, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid && (out_ch.column == $past(out_ch.column) + 2'd1), "column sequence broken")
  // A stall only comes from a full buffer with a matrix waiting behind it
  `TRS_ASSERT_NOW(a_stall_cause, !in_ch.ready, v15_r && ser_v_r, "input stalled without cause")
  // A new matrix starts at column zero
  `TRS_ASSERT_NEXT(a_first_col, ser_load, out_ch.valid && (out_ch.column == 2'd0), "matrix did not start at column zero")

endmodule

// ===== test/trs_model_matrix_test.sv =====
// Self-checking testbench for the transform matrix builder
module trs_model_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int           FRAC      = 16;
  localparam int           TURN      = 23040;
  localparam int           QUARTER   = 5760;
  localparam int           EIGHTH_T  = 2880;
  localparam bit           MODE_MODEL = 1'b0;
  localparam bit           MODE_GUI   = 1'b1;
  localparam int           CYCLE_LIMIT = 200000;
  localparam longint       QMAX = 64'sd2147483647;
  localparam longint       QMIN = -64'sd2147483648;

  typedef struct {
    bit                 func;
    logic signed [31:0] pos [3];
    logic signed [15:0] ang [3];
    logic signed [31:0] scl [3];
  } xform_t;

  typedef struct {
    logic [1:0]         column;
    logic signed [31:0] row [4];
    bit                 saturated;
    bit                 last;
  } column_t;

  logic clk;
  logic rst_n;
  int   mismatches = 0;
  int   cycles = 0;
  bit   steady;
  column_t column_q [$];

  trs_in_if  in_if ();
  trs_out_if out_if ();

  trs_model_matrix dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL trs_model_matrix");
      $finish;
    end
  end

  // Q2.30 product rounded half up
  function automatic longint unsigned mul30(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Q by Q product, rounded half up with floor
  function automatic longint qprod(longint a, longint b);
    return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s_o,
                                  output longint c_o);
    int                m, r, quad;
    bit                swap;
    longint unsigned   x, x2, t, s30, c30;
    longint            s, c, tmp;
    m = int'(ang) % TURN;
    if (m < 0) m += TURN;
    quad = m / QUARTER;
    r    = m % QUARTER;
    swap = 1'b0;
    if (r > EIGHTH_T) begin
      r    = QUARTER - r;
      swap = 1'b1;
    end
    x  = longint'(r) * 64'd292818;
    x2 = mul30(x, x);
    // sine series, innermost term first
    t   = (64'd1 << 30) - x2 / 72;
    t   = (64'd1 << 30) - mul30(x2 / 42, t);
    t   = (64'd1 << 30) - mul30(x2 / 20, t);
    t   = (64'd1 << 30) - mul30(x2 / 6, t);
    s30 = mul30(x, t);
    // cosine series
    t   = (64'd1 << 30) - x2 / 56;
    t   = (64'd1 << 30) - mul30(x2 / 30, t);
    t   = (64'd1 << 30) - mul30(x2 / 12, t);
    c30 = (64'd1 << 30) - mul30(x2 / 2, t);
    s = longint'((s30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    c = longint'((c30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
    if (swap) begin
      tmp = s; s = c; c = tmp;
    end
    case (quad)
      1:       begin s_o = c;  c_o = -s; end
      2:       begin s_o = -s; c_o = -c; end
      3:       begin s_o = -c; c_o = s;  end
      default: begin s_o = s;  c_o = c;  end
    endcase
  endfunction

  // Work out the four columns of one transform and queue them
  task automatic predict_columns(input xform_t t);
    longint  sx, cx, sy, cy, sz, cz, v;
    longint  rot [3][3];
    column_t col;
    sin_cos(t.ang[0], sx, cx);
    sin_cos(t.ang[1], sy, cy);
    sin_cos(t.ang[2], sz, cz);
    rot[0][0] = qprod(cy, cz);
    rot[0][1] = -qprod(cy, sz);
    rot[0][2] = sy;
    rot[1][0] = qprod(qprod(sx, sy), cz) + qprod(cx, sz);
    rot[1][1] = -qprod(qprod(sx, sy), sz) + qprod(cx, cz);
    rot[1][2] = -qprod(sx, cy);
    rot[2][0] = -qprod(qprod(cx, sy), cz) + qprod(sx, sz);
    rot[2][1] = qprod(qprod(cx, sy), sz) + qprod(sx, cz);
    rot[2][2] = qprod(cx, cy);
    for (int j = 0; j < 4; j++) begin
      col.saturated = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (j < 3) v = qprod(longint'(t.scl[i]), rot[i][j]);
        else if (t.func == MODE_GUI) v = longint'(t.pos[i]);
        else v = qprod(longint'(t.scl[i]), longint'(t.pos[i]));
        // clamp to the 32-bit range
        if (v > QMAX) begin
          v = QMAX; col.saturated = 1'b1;
        end else if (v < QMIN) begin
          v = QMIN; col.saturated = 1'b1;
        end
        col.row[i] = v[31:0];
      end
      col.column = j[1:0];
      col.row[3] = (j == 3) ? (32'sd1 <<< FRAC) : 32'sd0;
      col.last   = (j == 3);
      column_q.push_back(col);
    end
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= steady || ($urandom_range(99) >= 12);
  end

  // Compare each result transaction with the oldest expected column
  always @(posedge clk) begin
    column_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (column_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result column %0d", out_if.column);
      end else begin
        e = column_q.pop_front();
        if (out_if.column !== e.column || out_if.row0_value !== e.row[0] ||
            out_if.row1_value !== e.row[1] || out_if.row2_value !== e.row[2] ||
            out_if.row3_value !== e.row[3] || out_if.saturated !== e.saturated ||
            out_if.last !== e.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp col %0d %h %h %h %h sat %b last %b / got col %0d %h %h %h %h sat %b last %b",
                     e.column, e.row[0], e.row[1], e.row[2], e.row[3], e.saturated, e.last,
                     out_if.column, out_if.row0_value, out_if.row1_value, out_if.row2_value,
                     out_if.row3_value, out_if.saturated, out_if.last);
        end
      end
    end
  end

  // Send one transform, with a random hold-off before it
  task automatic send_transform(input xform_t t);
    while (!steady && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= t.func;
    in_if.pos_x   <= t.pos[0];
    in_if.pos_y   <= t.pos[1];
    in_if.pos_z   <= t.pos[2];
    in_if.angle_x <= t.ang[0];
    in_if.angle_y <= t.ang[1];
    in_if.angle_z <= t.ang[2];
    in_if.scale_x <= t.scl[0];
    in_if.scale_y <= t.scl[1];
    in_if.scale_z <= t.scl[2];
    do @(posedge clk); while (!in_if.ready);
    predict_columns(t);
  endtask

  function automatic xform_t make_xform(bit f, int p, int a0, int a1, int a2, int s);
    xform_t t;
    t.func = f;
    for (int i = 0; i < 3; i++) begin
      t.pos[i] = p;
      t.scl[i] = s;
    end
    t.ang[0] = 16'(a0); t.ang[1] = 16'(a1); t.ang[2] = 16'(a2);
    return t;
  endfunction

  // Identity, quadrant edges, octant swap, negative angles, field extremes
  task automatic test_directed();
    xform_t t;
    send_transform(make_xform(MODE_MODEL, 0, 0, 0, 0, 32'sh10000));
    send_transform(make_xform(MODE_GUI, 32'sh30000, 5760, 11520, 17280, 32'sh10000));
    send_transform(make_xform(MODE_MODEL, 32'sh20000, 2880, 2881, 2879, 32'sh18000));
    send_transform(make_xform(MODE_GUI, -32'sh20000, -1, -5760, -32768, 32'sh8000));
    send_transform(make_xform(MODE_MODEL, -32'sh10000, 32767, -23040, 23040, -32'sh10000));
    send_transform(make_xform(MODE_MODEL, 32'h7fffffff, 0, 0, 0, 32'h7fffffff));
    send_transform(make_xform(MODE_MODEL, 32'h80000000, 0, 0, 0, 32'h80000000));
    send_transform(make_xform(MODE_GUI, 32'h80000000, 1920, 640, 8000, 32'h7fffffff));
    send_transform(make_xform(MODE_MODEL, 32'hffffffff, 100, -100, 12345, 32'h80000000));
    send_transform(make_xform(MODE_GUI, 32'h7fffffff, -32768, 32767, 0, 32'hffffffff));
    t = make_xform(MODE_MODEL, 32'sh1234, 4000, 9000, -7000, 32'sh7fff0000);
    t.scl[1] = 32'sh80010000;
    send_transform(t);
  endtask

  // Random transforms, mostly moderate values with full-range ones mixed in
  task automatic test_random(int count);
    xform_t t;
    for (int k = 0; k < count; k++) begin
      steady = (k >= count / 3) && (k < count / 2);
      t.func = 1'($urandom_range(1));
      for (int i = 0; i < 3; i++) begin
        t.ang[i] = 16'($urandom);
        if ($urandom_range(3) == 0) begin
          t.pos[i] = $urandom;
          t.scl[i] = $urandom;
        end else begin
          t.pos[i] = $signed($urandom_range(32'h80000)) - 32'sh40000;
          t.scl[i] = $signed($urandom_range(32'h80000)) - 32'sh40000;
        end
      end
      send_transform(t);
    end
    steady = 1'b0;
  endtask

  // Stimulus, drain and verdict
  initial begin
    rst_n         = 1'b0;
    steady        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = 1'b0;
    in_if.pos_x   = '0;
    in_if.pos_y   = '0;
    in_if.pos_z   = '0;
    in_if.angle_x = '0;
    in_if.angle_y = '0;
    in_if.angle_z = '0;
    in_if.scale_x = '0;
    in_if.scale_y = '0;
    in_if.scale_z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(260);
    in_if.valid <= 1'b0;
    while (column_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && column_q.size() == 0) begin
      $display("PASS trs_model_matrix");
    end else begin
      $display("FAIL trs_model_matrix");
    end
    $finish;
  end

endmodule
